// File: sv/wbps_pkg.sv
`timescale 1ns / 1ps

package wbps_pkg;

  // Configuration port geometry: five 64-bit registers at 8-byte spacing
  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 6;
  localparam int REG_IDX_W  = 3;

  // Field widths fixed by the register map
  localparam int PAT_REG_BYTES = 8;
  localparam int PAT_BYTES_MAX = 16;
  localparam int CARE_W        = 16;
  localparam int LENGTH_W      = 5;
  localparam int ADDR_W        = 64;

  // Reset values of the registers that are not zero
  localparam logic [CARE_W-1:0]   CARE_RESET   = 16'hFFFF;
  localparam logic [LENGTH_W-1:0] LENGTH_RESET = 5'd1;

  // Register indexes (byte address bits 5:3)
  typedef enum logic [REG_IDX_W-1:0] {
    REG_PAT_LO = 3'd0,
    REG_PAT_HI = 3'd1,
    REG_CARE   = 3'd2,
    REG_LENGTH = 3'd3,
    REG_BASE   = 3'd4
  } wbps_reg_t;

  // Register contents as seen by the datapath
  typedef struct packed {
    logic [CFG_DATA_W-1:0] pat_lo;
    logic [CFG_DATA_W-1:0] pat_hi;
    logic [CARE_W-1:0]     care_mask;
    logic [LENGTH_W-1:0]   pattern_length;
    logic [ADDR_W-1:0]     base_address;
  } wbps_cfg_t;

endpackage

// File: sv/wbps_in_if.sv
`timescale 1ns / 1ps

// Input channel: one scanned byte per word
interface wbps_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_region;

  modport source (output valid, output data_byte, output end_of_region, input ready);
  modport sink   (input valid, input data_byte, input end_of_region, output ready);
endinterface

// File: sv/wbps_out_if.sv
`timescale 1ns / 1ps

// Result channel: start address of one match per word
interface wbps_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] match_address;

  modport source (output valid, output match_address, input ready);
  modport sink   (input valid, input match_address, output ready);
endinterface

// File: sv/wbps_cfg.sv
`timescale 1ns / 1ps

module wbps_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [wbps_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [wbps_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [wbps_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                               pready,
  output wbps_pkg::wbps_cfg_t                cfg
);

  wbps_pkg::wbps_cfg_t cfg_r;
  wbps_pkg::wbps_reg_t reg_idx;
  logic                wr_en;

  assign reg_idx = wbps_pkg::wbps_reg_t'(paddr[wbps_pkg::CFG_ADDR_W-1:3]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg     = cfg_r;

  // Register writes in the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pat_lo         <= '0;
      cfg_r.pat_hi         <= '0;
      cfg_r.care_mask      <= wbps_pkg::CARE_RESET;
      cfg_r.pattern_length <= wbps_pkg::LENGTH_RESET;
      cfg_r.base_address   <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        wbps_pkg::REG_PAT_LO: cfg_r.pat_lo <= pwdata;
        wbps_pkg::REG_PAT_HI: cfg_r.pat_hi <= pwdata;
        wbps_pkg::REG_CARE:   cfg_r.care_mask <= pwdata[wbps_pkg::CARE_W-1:0];
        wbps_pkg::REG_LENGTH: cfg_r.pattern_length <= pwdata[wbps_pkg::LENGTH_W-1:0];
        wbps_pkg::REG_BASE:   cfg_r.base_address <= pwdata;
        default: ;
      endcase
    end
  end

  // Read-back mux
  always_comb begin
    case (reg_idx)
      wbps_pkg::REG_PAT_LO: prdata = cfg_r.pat_lo;
      wbps_pkg::REG_PAT_HI: prdata = cfg_r.pat_hi;
      wbps_pkg::REG_CARE:   prdata = wbps_pkg::CFG_DATA_W'(cfg_r.care_mask);
      wbps_pkg::REG_LENGTH: prdata = wbps_pkg::CFG_DATA_W'(cfg_r.pattern_length);
      wbps_pkg::REG_BASE:   prdata = cfg_r.base_address;
      default:              prdata = '0;
    endcase
  end

endmodule

// File: sv/wbps_window.sv
`timescale 1ns / 1ps

module wbps_window #(
  parameter int PATTERN_BYTES = 16,
  parameter int FILL_W        = 5
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                adv,
  input  logic [7:0]                          data_byte,
  input  logic                                last,
  output logic [PATTERN_BYTES-1:0][7:0]       win_cur,
  output logic [FILL_W-1:0]                   fill_cur,
  output logic [wbps_pkg::ADDR_W-1:0]         offset_cur
);

  logic [PATTERN_BYTES-1:0][7:0]   window_r;
  logic [FILL_W-1:0]               fill_r;
  logic [wbps_pkg::ADDR_W-1:0]     offset_r;

  // Window as it stands once the staged byte is shifted in (entry 0 newest)
  always_comb begin
    win_cur[0] = data_byte;
    for (int j = 1; j < PATTERN_BYTES; j++) begin
      win_cur[j] = window_r[j-1];
    end
  end

  // Region fill saturates at the window depth
  assign fill_cur   = (fill_r == FILL_W'(PATTERN_BYTES)) ? fill_r : fill_r + FILL_W'(1);
  assign offset_cur = offset_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= '0;
      fill_r   <= '0;
      offset_r <= '0;
    end else if (adv) begin
      offset_r <= offset_r + wbps_pkg::ADDR_W'(1);
      if (last) begin
        window_r <= '0;
        fill_r   <= '0;
      end else begin
        window_r <= win_cur;
        fill_r   <= fill_cur;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(PATTERN_BYTES))
    else $error("region fill above window depth");

  a_region_clear: assert property (@(posedge clk) disable iff (!rst_n)
    adv && last |=> fill_r == '0 && window_r == '0)
    else $error("window not cleared after end of region");
`endif

endmodule

// File: sv/wbps_cmp.sv
`timescale 1ns / 1ps

module wbps_cmp #(
  parameter int PATTERN_BYTES = 16,
  parameter int FILL_W        = 5
) (
  input  wbps_pkg::wbps_cfg_t                 cfg,
  input  logic [PATTERN_BYTES-1:0][7:0]       win,
  input  logic [FILL_W-1:0]                   fill,
  input  logic [wbps_pkg::ADDR_W-1:0]         offset,
  output logic                                hit,
  output logic [wbps_pkg::ADDR_W-1:0]         addr
);

  localparam int EXT_W = (FILL_W > wbps_pkg::LENGTH_W) ? FILL_W : wbps_pkg::LENGTH_W;

  logic [EXT_W-1:0]                                 len_ext;
  logic [FILL_W-1:0]                                len;
  logic [wbps_pkg::PAT_BYTES_MAX-1:0][7:0]          pat;
  logic [PATTERN_BYTES-1:0][7:0]                    apat;
  logic [PATTERN_BYTES-1:0]                         acare;
  logic [PATTERN_BYTES-1:0]                         ok;

  assign pat = {cfg.pat_hi, cfg.pat_lo};

  // Effective length: zero counts as one, clamp to the window depth
  always_comb begin
    len_ext = EXT_W'(cfg.pattern_length);
    if (len_ext == '0) begin
      len_ext = EXT_W'(1);
    end
    if (len_ext > EXT_W'(PATTERN_BYTES)) begin
      len_ext = EXT_W'(PATTERN_BYTES);
    end
    len = len_ext[FILL_W-1:0];
  end

  // Align the pattern to window positions: window entry j meets pattern byte len-1-j
  always_comb begin
    logic [FILL_W-1:0] pi;
    logic [7:0]        ix;
    for (int j = 0; j < PATTERN_BYTES; j++) begin
      pi       = len - FILL_W'(1) - FILL_W'(j);
      ix       = 8'(pi);
      apat[j]  = pat[ix[3:0]];
      acare[j] = (FILL_W'(j) < len) && (ix < 8'(wbps_pkg::PAT_BYTES_MAX)) &&
                 cfg.care_mask[ix[3:0]];
    end
  end

  // Masked compare per window byte
  always_comb begin
    for (int j = 0; j < PATTERN_BYTES; j++) begin
      ok[j] = !acare[j] || (win[j] == apat[j]);
    end
  end

  assign hit  = (fill >= len) && (&ok);
  assign addr = cfg.base_address + offset - wbps_pkg::ADDR_W'(len - FILL_W'(1));

endmodule

// File: sv/wildcard_byte_pattern_scan_core.sv
`timescale 1ns / 1ps

// Wildcard byte signature scanner. One byte enters per word on in_ch; the
// block keeps the last PATTERN_BYTES bytes of the current region and, for
// each byte, checks the window ending there against the configured pattern
// (bytes whose care_mask bit is clear are wildcards). A hit emits one word on
// out_ch carrying base_address plus the stream offset of the match's first
// byte; a miss emits nothing. Throughput is one byte per clock while the
// result register is free or out_ch takes its word, set by the masked window
// compare, which is combinational between the input register and the result
// register. end_of_region clears the window after its byte is checked, while
// the offset keeps counting. Registers are written over the APB-style port
// at byte address 8*index and may be changed only while the scanner is idle.
module wildcard_byte_pattern_scan_core #(
  parameter int PATTERN_BYTES = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  wbps_in_if.sink                            in_ch,
  wbps_out_if.source                         out_ch,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [wbps_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [wbps_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [wbps_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                               pready
);

  localparam int FILL_W = $clog2(PATTERN_BYTES + 1);

  wbps_pkg::wbps_cfg_t              cfg;
  logic                             v1_r;
  logic [7:0]                       byte1_r;
  logic                             last1_r;
  logic                             adv;
  logic [PATTERN_BYTES-1:0][7:0]    win_cur;
  logic [FILL_W-1:0]                fill_cur;
  logic [wbps_pkg::ADDR_W-1:0]      offset_cur;
  logic                             hit;
  logic [wbps_pkg::ADDR_W-1:0]      addr;
  logic                             out_valid_r;
  logic [wbps_pkg::ADDR_W-1:0]      addr_r;

  wbps_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Staged byte moves on whenever the result register is free or draining
  assign adv         = v1_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !v1_r || adv;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      v1_r <= 1'b1;
    end else if (adv) begin
      v1_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      byte1_r <= in_ch.data_byte;
      last1_r <= in_ch.end_of_region;
    end
  end

  wbps_window #(
    .PATTERN_BYTES (PATTERN_BYTES),
    .FILL_W        (FILL_W)
  ) u_window (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .data_byte  (byte1_r),
    .last       (last1_r),
    .win_cur    (win_cur),
    .fill_cur   (fill_cur),
    .offset_cur (offset_cur)
  );

  wbps_cmp #(
    .PATTERN_BYTES (PATTERN_BYTES),
    .FILL_W        (FILL_W)
  ) u_cmp (
    .cfg    (cfg),
    .win    (win_cur),
    .fill   (fill_cur),
    .offset (offset_cur),
    .hit    (hit),
    .addr   (addr)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= hit;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && hit) begin
      addr_r <= addr;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.match_address = addr_r;

`ifndef NO_ASSERTIONS
  a_result_from_stage: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(v1_r))
    else $error("result appeared without a staged byte");

  a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r && !out_valid_r |-> in_ch.ready)
    else $error("input stalled while result register empty");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r && !v1_r)
    else $error("pipeline not empty after reset");
`endif

endmodule
